@@ src/xorshift64_star_generator_top_defines.svh @@
// Assertion macros shared by the generator RTL.
`ifndef XORSHIFT64_STAR_GENERATOR_TOP_DEFINES_SVH
`define XORSHIFT64_STAR_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define XS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define XS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/xs64_pkg.sv @@
package xs64_pkg;

	// Action codes carried in s_tuser
	typedef enum logic [1:0] {
		ACT_SEED   = 2'd0,
		ACT_NEXT   = 2'd1,
		ACT_RANGE  = 2'd2,
		ACT_CHANCE = 2'd3
	} action_t;

	localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
	localparam logic [63:0] STAR_MUL  = 64'h2545f4914f6cdd1d;
	localparam logic [63:0] SEED_ADD  = 64'h000000009e3779b9;
	localparam logic [63:0] ZERO_SUB  = 64'hd1b54a32d192ed03;
	localparam logic [24:0] PROB_ONE  = 25'h1000000;
	localparam logic [31:0] SIGN_BIT  = 32'h80000000;

	// Index of the last partial product of a 64x64 low-half multiply
	localparam logic [1:0] MUL_LAST = 2'd2;

endpackage

@@ src/xorshift64_star_generator_top.sv @@
// A range runs the remainder loop unless its span wraps to zero; empty ranges and zero
// or certain probabilities answer in the cycle after the beat.
// Throughput: one item at a time; the shared 32x32 multiplier (3 partial products per
// 64-bit multiply) and the 1-bit-per-cycle remainder loop set the pace.
// Reset: async active low; afterwards the block seeds itself with zero (s_tready low),
// then the generator holds the seed-zero state.
`include "xorshift64_star_generator_top_defines.svh"

module xorshift64_star_generator_top
	import xs64_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] seed_value, [63:32] range_low, [95:64] range_high,
	// [120:96] probability, [127:121] zero
	input  logic [127:0] s_tdata,
	// [1:0] action
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] raw_value, [63:32] range_value, [64] hit, [71:65] zero
	output logic [71:0]  m_tdata
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MUL,
		ST_POST,
		ST_DIV
	} fsm_t;

	fsm_t        fsm_q;
	action_t     act_q;
	logic [1:0]  pass_q;
	logic [1:0]  mstep_q;
	logic [63:0] gen_q;
	logic [63:0] mul_a_q;
	logic [63:0] mul_b_q;
	logic [63:0] acc_q;
	logic [31:0] lo_q;
	logic [31:0] span_q;
	logic [24:0] prob_q;
	logic [31:0] dvd_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic [31:0] raw_q;
	logic [31:0] rval_q;
	logic        hit_q;
	logic        out_valid_q;
	logic        init_done_q;

	// Input field split
	action_t     in_act;
	logic [31:0] in_seed;
	logic [31:0] in_lo;
	logic [31:0] in_hi;
	logic [24:0] in_prob;
	logic [31:0] in_span;
	logic        in_empty;
	logic        accept;
	logic        out_free;

	assign in_act   = action_t'(s_tuser);
	assign in_seed  = s_tdata[31:0];
	assign in_lo    = s_tdata[63:32];
	assign in_hi    = s_tdata[95:64];
	assign in_prob  = s_tdata[120:96];
	assign in_span  = in_hi - in_lo + 32'd1;
	assign in_empty = (in_hi ^ SIGN_BIT) <= (in_lo ^ SIGN_BIT);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (fsm_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, hit_q, rval_q, raw_q};

	// xorshift64 advance of the held state
	logic [63:0] xs1, xs2, xs3;
	assign xs1 = gen_q ^ (gen_q >> 12);
	assign xs2 = xs1 ^ (xs1 << 25);
	assign xs3 = xs2 ^ (xs2 >> 27);

	// Shared multiplier: one 32x32 partial product of mul_a_q * mul_b_q per cycle
	logic [31:0] mx, my;
	logic [63:0] prod;
	always_comb begin
		unique case (mstep_q)
			2'd0:    begin mx = mul_a_q[31:0];  my = mul_b_q[31:0];  end
			2'd1:    begin mx = mul_a_q[31:0];  my = mul_b_q[63:32]; end
			default: begin mx = mul_a_q[63:32]; my = mul_b_q[31:0];  end
		endcase
		prod = mx * my;
	end

	// Finalizer steps on the finished product
	logic [63:0] v_add, mix1, mix2, mix3, seeded;
	logic [31:0] raw_now;
	assign v_add   = acc_q + SEED_ADD;
	assign mix1    = v_add ^ (v_add >> 30);
	assign mix2    = acc_q ^ (acc_q >> 27);
	assign mix3    = acc_q ^ (acc_q >> 31);
	assign seeded  = (mix3 == 64'd0) ? ZERO_SUB : mix3;
	assign raw_now = acc_q[63:32];

	// Restoring remainder step
	logic [32:0] trial;
	logic [31:0] rem_next;
	assign trial    = {rem_q, dvd_q[31]};
	assign rem_next = (trial >= {1'b0, span_q}) ? 32'(trial - {1'b0, span_q}) : trial[31:0];

	// Sequencer, generator state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= ST_INIT;
			out_valid_q <= 1'b0;
			act_q       <= ACT_SEED;
			pass_q      <= 2'd0;
			mstep_q     <= 2'd0;
			cnt_q       <= 5'd0;
		end else begin
			unique case (fsm_q)
				// seed with zero after reset, no result
				ST_INIT: begin
					act_q   <= ACT_SEED;
					pass_q  <= 2'd0;
					mstep_q <= 2'd0;
					mul_a_q <= 64'd0;
					mul_b_q <= STAR_MUL;
					fsm_q   <= ST_MUL;
				end

				ST_IDLE: begin
					if (accept) begin
						act_q   <= in_act;
						lo_q    <= in_lo;
						span_q  <= in_span;
						prob_q  <= in_prob;
						pass_q  <= 2'd0;
						mstep_q <= 2'd0;
						mul_b_q <= STAR_MUL;
						raw_q   <= 32'd0;
						rval_q  <= 32'd0;
						hit_q   <= 1'b0;
						unique case (in_act)
							ACT_SEED: begin
								mul_a_q     <= {32'd0, in_seed};
								out_valid_q <= 1'b0;
								fsm_q       <= ST_MUL;
							end
							ACT_NEXT: begin
								gen_q       <= xs3;
								mul_a_q     <= xs3;
								out_valid_q <= 1'b0;
								fsm_q       <= ST_MUL;
							end
							ACT_RANGE: begin
								if (in_empty) begin
									rval_q      <= in_lo;
									out_valid_q <= 1'b1;
								end else begin
									gen_q       <= xs3;
									mul_a_q     <= xs3;
									out_valid_q <= 1'b0;
									fsm_q       <= ST_MUL;
								end
							end
							default: begin
								if (in_prob == 25'd0) begin
									out_valid_q <= 1'b1;
								end else if (in_prob >= PROB_ONE) begin
									hit_q       <= 1'b1;
									out_valid_q <= 1'b1;
								end else begin
									gen_q       <= xs3;
									mul_a_q     <= xs3;
									out_valid_q <= 1'b0;
									fsm_q       <= ST_MUL;
								end
							end
						endcase
					end else if (m_tready) begin
						// drop the beat once taken
						out_valid_q <= 1'b0;
					end
				end

				// accumulate the low 64 bits over three partial products
				ST_MUL: begin
					if (mstep_q == 2'd0)
						acc_q <= prod;
					else
						acc_q <= acc_q + {prod[31:0], 32'd0};
					if (mstep_q == MUL_LAST) begin
						mstep_q <= 2'd0;
						fsm_q   <= ST_POST;
					end else begin
						mstep_q <= mstep_q + 2'd1;
					end
				end

				ST_POST: begin
					unique case (act_q)
						ACT_SEED: begin
							priority if (pass_q == 2'd0) begin
								mul_a_q <= mix1;
								mul_b_q <= MIX_MUL_A;
								pass_q  <= 2'd1;
								fsm_q   <= ST_MUL;
							end else if (pass_q == 2'd1) begin
								mul_a_q <= mix2;
								mul_b_q <= MIX_MUL_B;
								pass_q  <= 2'd2;
								fsm_q   <= ST_MUL;
							end else begin
								gen_q <= seeded;
								fsm_q <= ST_IDLE;
								// the self-seed after reset gives no result
								if (init_done_q)
									out_valid_q <= 1'b1;
							end
						end
						ACT_NEXT: begin
							raw_q       <= raw_now;
							out_valid_q <= 1'b1;
							fsm_q       <= ST_IDLE;
						end
						ACT_RANGE: begin
							raw_q <= raw_now;
							if (span_q == 32'd0) begin
								rval_q      <= lo_q + raw_now;
								out_valid_q <= 1'b1;
								fsm_q       <= ST_IDLE;
							end else begin
								dvd_q <= raw_now;
								rem_q <= 32'd0;
								cnt_q <= 5'd0;
								fsm_q <= ST_DIV;
							end
						end
						default: begin
							raw_q       <= raw_now;
							hit_q       <= {1'b0, raw_now[31:8]} < prob_q;
							out_valid_q <= 1'b1;
							fsm_q       <= ST_IDLE;
						end
					endcase
				end

				// one remainder bit per cycle
				ST_DIV: begin
					rem_q <= rem_next;
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						rval_q      <= lo_q + rem_next;
						out_valid_q <= 1'b1;
						fsm_q       <= ST_IDLE;
					end
				end

				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

	// Mark the end of the self-seed after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			init_done_q <= 1'b0;
		else if (fsm_q == ST_POST && act_q == ACT_SEED && pass_q == 2'd2)
			init_done_q <= 1'b1;
	end

	`XS_ASSERT_NOW(a_busy_not_ready, fsm_q != ST_IDLE, !s_tready, "ready while busy")
	`XS_ASSERT_NOW(a_state_nonzero, fsm_q == ST_IDLE, gen_q != 64'd0, "generator state zero")
	`XS_ASSERT_NOW(a_rem_below_span, fsm_q == ST_DIV, rem_q < span_q, "remainder not below span")
	`XS_ASSERT_NEXT(a_empty_range_result, accept && in_act == ACT_RANGE && in_empty,
		m_tvalid && m_tdata[63:32] == $past(in_lo), "empty range result wrong")

endmodule

@@ tb/tb.sv @@
module tb;
	import xs64_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Generator constants, kept apart from the RTL package
	localparam logic [63:0] FIN_MUL_1  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] FIN_MUL_2  = 64'h94d049bb133111eb;
	localparam logic [63:0] STAR_K     = 64'h2545f4914f6cdd1d;
	localparam logic [63:0] GOLDEN_ADD = 64'h000000009e3779b9;
	localparam logic [63:0] ZERO_FILL  = 64'hd1b54a32d192ed03;
	localparam logic [24:0] PROB_FULL  = 25'h1000000;
	localparam logic [31:0] INT_MIN    = 32'h80000000;
	localparam logic [31:0] INT_MAX    = 32'h7fffffff;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          RANDOM_ITEMS = 1250;

	typedef struct packed {
		logic [31:0] raw;
		logic [31:0] rng;
		logic        hit;
	} gen_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// [31:0] seed_value, [63:32] range_low, [95:64] range_high,
	// [120:96] probability, [127:121] zero
	logic [127:0] s_tdata = '0;
	// [1:0] action
	logic [1:0]   s_tuser = ACT_SEED;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// [31:0] raw_value, [63:32] range_value, [64] hit, [71:65] zero
	logic [71:0]  m_tdata;

	logic [63:0]  gen_state;
	gen_result_t  results_due[$];
	int           fault_count = 0;
	int           cycle_count = 0;
	bit           quiet = 1'b0;
	int           hold_ask = 0;
	int           hold_left = 0;

	xorshift64_star_generator_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// splitmix64 finalizer
	function automatic logic [63:0] splitmix_finish(logic [63:0] v);
		v = (v ^ (v >> 30)) * FIN_MUL_1;
		v = (v ^ (v >> 27)) * FIN_MUL_2;
		return v ^ (v >> 31);
	endfunction

	function automatic void reseed(logic [31:0] seed);
		logic [63:0] v;
		v = splitmix_finish({32'b0, seed} * STAR_K + GOLDEN_ADD);
		gen_state = (v == 64'd0) ? ZERO_FILL : v;
	endfunction

	// xorshift64* step, high half of the scrambled state
	function automatic logic [31:0] step_generator();
		logic [63:0] x;
		logic [63:0] prod;
		x = gen_state;
		x ^= x >> 12;
		x ^= x << 25;
		x ^= x >> 27;
		gen_state = x;
		prod = x * STAR_K;
		return prod[63:32];
	endfunction

	// Expected beat for one accepted item; advances gen_state as the block does
	function automatic gen_result_t predict_output(action_t act, logic [31:0] seed,
			logic [31:0] lo, logic [31:0] hi, logic [24:0] prob);
		gen_result_t r;
		logic [31:0] span;
		r = '0;
		case (act)
			ACT_SEED: reseed(seed);
			ACT_NEXT: r.raw = step_generator();
			ACT_RANGE: begin
				if ($signed(hi) <= $signed(lo)) begin
					r.rng = lo;
				end else begin
					span = hi - lo + 32'd1;
					r.raw = step_generator();
					r.rng = (span == 32'd0) ? lo + r.raw : lo + (r.raw % span);
				end
			end
			default: begin
				if (prob == 25'd0) begin
					r.hit = 1'b0;
				end else if (prob >= PROB_FULL) begin
					r.hit = 1'b1;
				end else begin
					r.raw = step_generator();
					r.hit = ({1'b0, r.raw[31:8]} < prob);
				end
			end
		endcase
		return r;
	endfunction

	// Offer one beat, idling now and then, and record its expected result on acceptance
	task automatic send_item(action_t act, logic [31:0] seed, logic [31:0] lo,
			logic [31:0] hi, logic [24:0] prob);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'b0, prob, hi, lo, seed};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		results_due.push_back(predict_output(act, seed, lo, hi, prob));
	endtask

	// Hold the input quiet until every expected beat has come back
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [24:0] any_prob();
		return 25'($urandom);
	endfunction

	task automatic test_reset_state();
		send_item(ACT_NEXT, $urandom, $urandom, $urandom, any_prob());
		send_item(ACT_NEXT, $urandom, $urandom, $urandom, any_prob());
	endtask

	task automatic test_seed();
		send_item(ACT_SEED, 32'h0, $urandom, $urandom, any_prob());
		send_item(ACT_NEXT, $urandom, $urandom, $urandom, any_prob());
		send_item(ACT_SEED, 32'hffffffff, $urandom, $urandom, any_prob());
		send_item(ACT_NEXT, $urandom, $urandom, $urandom, any_prob());
		send_item(ACT_SEED, $urandom, $urandom, $urandom, any_prob());
	endtask

	task automatic test_range();
		// empty and inverted bounds: no advance
		send_item(ACT_RANGE, $urandom, 32'd7, 32'd7, any_prob());
		send_item(ACT_RANGE, $urandom, INT_MAX, INT_MIN, any_prob());
		send_item(ACT_RANGE, $urandom, 32'd5, 32'hfffffffb, any_prob());
		// full-width span wraps to zero
		send_item(ACT_RANGE, $urandom, INT_MIN, INT_MAX, any_prob());
		send_item(ACT_RANGE, $urandom, 32'd0, 32'd1, any_prob());
		send_item(ACT_RANGE, $urandom, 32'hfffffffb, 32'd5, any_prob());
		send_item(ACT_RANGE, $urandom, INT_MIN, INT_MIN + 32'd1, any_prob());
		send_item(ACT_RANGE, $urandom, INT_MAX - 32'd1, INT_MAX, any_prob());
		send_item(ACT_RANGE, $urandom, INT_MIN, INT_MAX - 32'd1, any_prob());
	endtask

	task automatic test_chance();
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, 25'd0);
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, 25'd1);
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, PROB_FULL - 25'd1);
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, PROB_FULL);
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, 25'h1ffffff);
		send_item(ACT_CHANCE, $urandom, $urandom, $urandom, 25'h0800000);
	endtask

	// Stall the receiver for a long stretch while the sender keeps offering beats
	task automatic test_backpressure();
		@(posedge clk);
		hold_ask = 400;
		repeat (8)
			send_item(action_t'($urandom_range(1, 3)), $urandom, 32'd0, 32'd1000,
				25'($urandom_range(1, 25'hffffff)));
		wait_drain();
	endtask

	// Let the block drain completely, then resume
	task automatic test_pause_resume();
		wait_drain();
		send_item(ACT_NEXT, $urandom, $urandom, $urandom, any_prob());
		send_item(ACT_RANGE, $urandom, 32'hffffff00, 32'd255, any_prob());
	endtask

	task automatic test_random_mix();
		action_t     act;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [24:0] prob;
		int          pick;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 500 && i < 700);
			pick = $urandom_range(99);
			act = (pick < 6) ? ACT_SEED : (pick < 30) ? ACT_NEXT :
				(pick < 70) ? ACT_RANGE : ACT_CHANCE;
			lo = $urandom;
			hi = $urandom;
			prob = any_prob();
			if (act == ACT_RANGE) begin
				pick = $urandom_range(99);
				if (pick < 45)
					hi = lo + $urandom_range(1, 300);
				else if (pick < 65)
					hi = lo + ($urandom >> $urandom_range(0, 31));
				else if (pick < 75)
					lo = INT_MIN + $urandom_range(0, 3);
				else if (pick < 82)
					hi = INT_MAX - $urandom_range(0, 3);
				else if (pick < 90)
					hi = lo;
				else if (pick < 95) begin
					lo = INT_MIN;
					hi = INT_MAX;
				end
			end else if (act == ACT_CHANCE) begin
				pick = $urandom_range(99);
				if (pick < 10)
					prob = 25'd0;
				else if (pick < 20)
					prob = {1'b1, 24'($urandom)};
				else
					prob = 25'($urandom_range(1, 25'hffffff));
			end
			send_item(act, $urandom, lo, hi, prob);
		end
		quiet = 1'b0;
	endtask

	// Drive the receiver ready: long holds on request, random stalls otherwise
	always @(negedge clk) begin
		if (hold_ask != 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= 10);
		end
	end

	// Check each output beat against the oldest expectation
	always @(posedge clk) begin
		gen_result_t want;
		gen_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[63:32], m_tdata[64]};
			if (results_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected beat: raw %h range %h hit %b",
						got.raw, got.rng, got.hit);
			end else begin
				want = results_due.pop_front();
				if (got.raw !== want.raw || got.rng !== want.rng || got.hit !== want.hit) begin
					fault_count++;
					if (fault_count <= 10)
						$display("mismatch: raw %h/%h range %h/%h hit %b/%b (exp/got)",
							want.raw, got.raw, want.rng, got.rng, want.hit, got.hit);
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		reseed(32'd0);
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_seed();
		test_range();
		test_chance();
		test_backpressure();
		test_pause_resume();
		test_random_mix();
		wait_drain();
		repeat (60) @(posedge clk);
		if (fault_count == 0 && results_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
